@@ src/asp_pkg.sv @@
// Package for the aging slot pool: types, constants and codes.
package asp_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int LIST_MAX = 16;
  localparam logic [15:0] DT_MAX_MS = 16'd100;
  localparam logic [23:0] REACH_MIN = 24'd26;
  localparam logic [19:0] AGE_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    REQ_SPAWN = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_SPAWN = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               keep_forever;
    logic [19:0]        life_ms;
    logic [15:0]        delta_ms;
    logic [23:0]        reach;
    logic [4:0]         list_room;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        entry_id;
    logic signed [23:0] entry_x;
    logic signed [23:0] entry_y;
    logic signed [23:0] entry_z;
    logic               entry_persistent;
    logic [19:0]        entry_life;
    logic [19:0]        entry_age;
    logic [4:0]         live_total;
    logic [4:0]         listed_total;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIST,
    ST_SUM,
    ST_EVICT,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;     // capture the request
    logic             scan_rst; // set slot index to zero
    logic             step;     // advance slot index
    logic             tick_upd; // age the current slot
    logic             sq_en;    // register squared deltas
    logic             sum;      // register distance compare
    logic             emit_ent; // list current slot
    logic             spawn_wr; // write picked slot
    logic             emit_fin; // emit final result
    logic             clear;    // empty the pool
  } dp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic             slot_last; // index at final slot
    logic             cur_live;
    logic             cur_keep;
    logic             in_reach;
    logic             room_left;
    logic             have_free;
    logic [1:0]       req;
  } dp_sts_t;

endpackage

@@ src/asp_ctrl.sv @@
// Controller state machine for the aging slot pool.
module asp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  asp_pkg::dp_sts_t sts,
  output asp_pkg::dp_cmd_t cmd
);
  import asp_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_rst = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (sts.req)
          REQ_SPAWN: begin
            // Free slot search was done in one lookup; else walk from cursor.
            if (sts.have_free) begin
              cmd.spawn_wr = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_EVICT;
            end
          end
          REQ_TICK: begin
            cmd.tick_upd = 1'b1;
            cmd.step = 1'b1;
            if (sts.slot_last) state_nxt = ST_DONE;
          end
          REQ_QUERY: begin
            cmd.sq_en = 1'b1;
            state_nxt = ST_DIST;
          end
          default: begin
            cmd.clear = 1'b1;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DIST: begin
        cmd.sum = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sts.cur_live && sts.room_left && sts.in_reach) cmd.emit_ent = 1'b1;
        cmd.step = 1'b1;
        state_nxt = sts.slot_last ? ST_DONE : ST_SCAN;
      end
      ST_EVICT: begin
        // Walk from the cursor until a non-persistent slot is found or every slot has been tried.
        if (!sts.cur_keep) begin
          cmd.spawn_wr = 1'b1;
          state_nxt = ST_DONE;
        end else if (sts.slot_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit_fin = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ src/asp_dp.sv @@
// Datapath for the aging slot pool: slot store, distance unit, result register.
module asp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  asp_pkg::in_item_t   in_item,
  input  asp_pkg::dp_cmd_t    cmd,
  output asp_pkg::dp_sts_t    sts,
  output logic                out_valid,
  output asp_pkg::out_item_t  out_item
);
  import asp_pkg::*;

  logic [SLOTS-1:0]        live_r;
  logic [SLOTS-1:0]        keep_r;
  logic signed [23:0]      px_r [SLOTS];
  logic signed [23:0]      py_r [SLOTS];
  logic signed [23:0]      pz_r [SLOTS];
  logic [19:0]             life_r [SLOTS];
  logic [19:0]             age_r [SLOTS];
  logic [31:0]             tag_r [SLOTS];
  logic [31:0]             next_tag_r;
  logic [SLOT_W-1:0]       cursor_r;
  logic [CNT_W-1:0]        live_cnt_r;

  in_item_t                req_r;
  logic [SLOT_W-1:0]       idx_r;
  logic [4:0]              listed_r;
  logic [4:0]              room_r;
  logic [47:0]             reach_sq_r;
  logic [47:0]             dx2_r, dy2_r, dz2_r;
  logic                    in_reach_r;
  logic [6:0]              dt_r;
  logic                    out_valid_r;
  out_item_t               out_r;
  out_item_t               out_nxt;
  logic [31:0]             spawn_id_r;

  logic [SLOT_W-1:0]       free_idx;
  logic                    have_free;
  logic [SLOT_W-1:0]       pick;
  logic [24:0]             ddx, ddy, ddz;
  logic [24:0]             adx, ady, adz;
  logic [23:0]             reach_c;
  logic [20:0]             age_sum;
  logic [19:0]             age_new;
  logic [49:0]             dsum;
  logic [31:0]             tag_inc;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    have_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_idx = SLOT_W'(i);
        have_free = 1'b1;
      end
    end
  end

  // Cursor walk index for eviction, or plain scan index.
  assign pick = (req_r.req_type == REQ_SPAWN) ?
                (have_free ? free_idx : SLOT_W'(cursor_r + idx_r)) : idx_r;

  // Absolute coordinate differences for the current slot.
  assign ddx = {px_r[idx_r][23], px_r[idx_r]} - {req_r.pos_x[23], req_r.pos_x};
  assign ddy = {py_r[idx_r][23], py_r[idx_r]} - {req_r.pos_y[23], req_r.pos_y};
  assign ddz = {pz_r[idx_r][23], pz_r[idx_r]} - {req_r.pos_z[23], req_r.pos_z};
  assign adx = ddx[24] ? -ddx : ddx;
  assign ady = ddy[24] ? -ddy : ddy;
  assign adz = ddz[24] ? -ddz : ddz;
  assign dsum = {2'b00, dx2_r} + {2'b00, dy2_r} + {2'b00, dz2_r};
  assign reach_c = (in_item.reach < REACH_MIN) ? REACH_MIN : in_item.reach;

  // Saturating age for the current slot.
  assign age_sum = {1'b0, age_r[idx_r]} + {14'd0, dt_r};
  assign age_new = age_sum[20] ? AGE_MAX : age_sum[19:0];
  assign tag_inc = (next_tag_r + 32'd1 == 32'd0) ? 32'd1 : next_tag_r + 32'd1;

  assign sts.slot_last = (idx_r == SLOT_W'(SLOTS - 1));
  assign sts.cur_live  = live_r[idx_r];
  assign sts.cur_keep  = keep_r[pick];
  assign sts.in_reach  = in_reach_r;
  assign sts.room_left = (listed_r < room_r);
  assign sts.have_free = have_free;
  assign sts.req       = req_r.req_type;

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
      reach_sq_r <= 48'(reach_c) * 48'(reach_c);
      room_r <= (in_item.list_room > 5'(LIST_MAX)) ? 5'(LIST_MAX) : in_item.list_room;
      dt_r <= (in_item.delta_ms > DT_MAX_MS) ? 7'(DT_MAX_MS) : in_item.delta_ms[6:0];
      listed_r <= '0;
    end
    if (cmd.scan_rst) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
    end
    // The magnitudes fit in 24 bits, so each square fits in 48.
    if (cmd.sq_en) begin
      dx2_r <= 48'(adx[23:0]) * 48'(adx[23:0]);
      dy2_r <= 48'(ady[23:0]) * 48'(ady[23:0]);
      dz2_r <= 48'(adz[23:0]) * 48'(adz[23:0]);
    end
    if (cmd.sum) in_reach_r <= (dsum <= {2'b00, reach_sq_r});
    if (cmd.emit_ent) listed_r <= listed_r + 5'd1;
  end

  // Slot store and pool counters.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      live_r <= '0;
      keep_r <= '0;
      next_tag_r <= 32'd1;
      cursor_r <= '0;
      live_cnt_r <= '0;
    end else begin
      if (cmd.tick_upd && live_r[idx_r]) begin
        if (!keep_r[idx_r] && life_r[idx_r] != 20'd0 && age_new >= life_r[idx_r]) begin
          live_r[idx_r] <= 1'b0;
          live_cnt_r <= live_cnt_r - 1'b1;
        end
      end
      if (cmd.spawn_wr) begin
        live_r[pick] <= 1'b1;
        keep_r[pick] <= req_r.keep_forever;
        next_tag_r <= tag_inc;
        if (have_free) live_cnt_r <= live_cnt_r + 1'b1;
        else cursor_r <= pick + 1'b1;
      end
    end
  end

  // Slot payload, no reset needed; a slot reads only after it is written.
  always_ff @(posedge clk) begin
    if (cmd.tick_upd && live_r[idx_r]) age_r[idx_r] <= age_new;
    if (cmd.spawn_wr) begin
      px_r[pick] <= req_r.pos_x;
      py_r[pick] <= req_r.pos_y;
      pz_r[pick] <= req_r.pos_z;
      life_r[pick] <= req_r.life_ms;
      age_r[pick] <= '0;
      tag_r[pick] <= next_tag_r;
    end
  end

  // Spawn answer id: remember the id handed out, or zero on failure.
  always_ff @(posedge clk) begin
    if (cmd.load) spawn_id_r <= '0;
    else if (cmd.spawn_wr) spawn_id_r <= next_tag_r;
  end

  // Next result.
  always_comb begin
    out_nxt = '0;
    out_nxt.live_total = 5'(live_cnt_r);
    if (cmd.emit_ent) begin
      out_nxt.kind = KIND_ENTRY;
      out_nxt.entry_id = tag_r[idx_r];
      out_nxt.entry_x = px_r[idx_r];
      out_nxt.entry_y = py_r[idx_r];
      out_nxt.entry_z = pz_r[idx_r];
      out_nxt.entry_persistent = keep_r[idx_r];
      out_nxt.entry_life = life_r[idx_r];
      out_nxt.entry_age = age_r[idx_r];
    end else if (cmd.emit_fin) begin
      out_nxt.last = 1'b1;
      case (req_r.req_type)
        REQ_SPAWN: begin
          out_nxt.kind = KIND_SPAWN;
          out_nxt.entry_id = spawn_id_r;
        end
        REQ_QUERY: begin
          out_nxt.kind = KIND_END;
          out_nxt.listed_total = listed_r;
        end
        default: out_nxt.kind = KIND_DONE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ent || cmd.emit_fin;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

@@ src/aging_slot_pool_with_overwrite.sv @@
// Top level of the aging slot pool with overwrite.
// One item at a time: raise start with in_item while busy is low. A spawn writes
// a free slot at once, or else walks the 16 slots from the eviction cursor; a tick
// ages every slot in turn and a clear empties the pool; a query works through each
// slot in turn (delta and square, compare, list). Results come
// one per out_valid pulse and cannot be stalled; the last carries last=1.
module aging_slot_pool_with_overwrite (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  asp_pkg::in_item_t   in_item,
  output logic                out_valid,
  output asp_pkg::out_item_t  out_item
);
  import asp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  asp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  asp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // An entry result never appears while idle and the last result ends the item.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy) else $error("entry result while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy) else $error("final result while busy");
  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not start");
`endif

endmodule

@@ sim/asp_checker.sv @@
// Checker for the aging slot pool: watches items, predicts results and compares them.
`timescale 1ns / 100ps

module asp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  asp_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  asp_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending,
  output int                 listed_seen
);
  import asp_pkg::*;

  // Shadow copy of the pool.
  logic               pool_live [SLOTS];
  logic               pool_keep [SLOTS];
  logic signed [23:0] pool_x [SLOTS];
  logic signed [23:0] pool_y [SLOTS];
  logic signed [23:0] pool_z [SLOTS];
  logic [19:0]        pool_life [SLOTS];
  logic [19:0]        pool_age [SLOTS];
  logic [31:0]        pool_tag [SLOTS];
  logic [31:0]        tag_next;
  logic [3:0]         cursor;
  logic [4:0]         live_cnt;

  out_item_t want_q[$];

  assign pending = want_q.size();

  function automatic out_item_t blank_result(kind_t k);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.live_total = live_cnt;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic empty_pool();
    for (int i = 0; i < SLOTS; i++) begin
      pool_live[i] = 0; pool_keep[i] = 0; pool_x[i] = 0; pool_y[i] = 0;
      pool_z[i] = 0; pool_life[i] = 0; pool_age[i] = 0; pool_tag[i] = 0;
    end
    tag_next = 32'd1;
    cursor = '0;
    live_cnt = '0;
  endtask

  function automatic longint sq24(logic signed [23:0] a, logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // Work out the results of one accepted item and apply it to the shadow pool.
  task automatic predict_pool(in_item_t it);
    int pick;
    int c;
    int dt;
    int age;
    int room;
    int listed;
    longint rr;
    longint lim;
    out_item_t r;
    case (req_t'(it.req_type))
      REQ_SPAWN: begin
        pick = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!pool_live[i] && pick < 0) pick = i;
        if (pick < 0) begin
          for (int a = 0; a < SLOTS; a++) begin
            c = (int'(cursor) + a) % SLOTS;
            if (!pool_keep[c] && pick < 0) begin
              pick = c;
              cursor = 4'((c + 1) % SLOTS);
            end
          end
        end
        r = blank_result(KIND_SPAWN);
        if (pick >= 0) begin
          if (!pool_live[pick]) live_cnt++;
          r.entry_id = tag_next;
          r.live_total = live_cnt;
          tag_next++;
          if (tag_next == 0) tag_next = 32'd1;
          pool_live[pick] = 1; pool_keep[pick] = it.keep_forever;
          pool_x[pick] = it.pos_x; pool_y[pick] = it.pos_y; pool_z[pick] = it.pos_z;
          pool_life[pick] = it.life_ms; pool_age[pick] = 0;
          pool_tag[pick] = r.entry_id;
        end
        want_q.push_back(r);
      end
      REQ_TICK: begin
        dt = (it.delta_ms > DT_MAX_MS) ? int'(DT_MAX_MS) : int'(it.delta_ms);
        for (int i = 0; i < SLOTS; i++) begin
          if (pool_live[i]) begin
            age = int'(pool_age[i]) + dt;
            if (age > int'(AGE_MAX)) age = int'(AGE_MAX);
            pool_age[i] = 20'(age);
            if (!pool_keep[i] && pool_life[i] != 0 && pool_age[i] >= pool_life[i]) begin
              pool_live[i] = 0;
              if (live_cnt > 0) live_cnt--;
            end
          end
        end
        want_q.push_back(blank_result(KIND_DONE));
      end
      REQ_QUERY: begin
        rr = (it.reach < REACH_MIN) ? longint'(REACH_MIN) : longint'(it.reach);
        lim = rr * rr;
        room = (it.list_room > LIST_MAX) ? LIST_MAX : int'(it.list_room);
        listed = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (pool_live[i] && listed < room &&
              sq24(pool_x[i], it.pos_x) + sq24(pool_y[i], it.pos_y) +
              sq24(pool_z[i], it.pos_z) <= lim) begin
            r = blank_result(KIND_ENTRY);
            r.last = 0;
            r.entry_id = pool_tag[i];
            r.entry_x = pool_x[i]; r.entry_y = pool_y[i]; r.entry_z = pool_z[i];
            r.entry_persistent = pool_keep[i];
            r.entry_life = pool_life[i]; r.entry_age = pool_age[i];
            want_q.push_back(r);
            listed++;
          end
        end
        r = blank_result(KIND_END);
        r.listed_total = 5'(listed);
        want_q.push_back(r);
      end
      default: begin
        empty_pool();
        want_q.push_back(blank_result(KIND_DONE));
      end
    endcase
  endtask

  // Compare one field and count a mismatch.
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      fail_count = 0;
      listed_seen = 0;
      empty_pool();
      want_q.delete();
    end else begin
      if (out_valid) begin
        if (want_q.size() == 0) begin
          $error("result with no item pending, kind %0d", out_item.kind);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (out_item.kind == KIND_ENTRY) listed_seen++;
          check_field("kind", w.kind, out_item.kind);
          check_field("entry_id", w.entry_id, out_item.entry_id);
          check_field("entry_x", w.entry_x, out_item.entry_x);
          check_field("entry_y", w.entry_y, out_item.entry_y);
          check_field("entry_z", w.entry_z, out_item.entry_z);
          check_field("entry_persistent", w.entry_persistent, out_item.entry_persistent);
          check_field("entry_life", w.entry_life, out_item.entry_life);
          check_field("entry_age", w.entry_age, out_item.entry_age);
          check_field("live_total", w.live_total, out_item.live_total);
          check_field("listed_total", w.listed_total, out_item.listed_total);
          check_field("last", w.last, out_item.last);
        end
      end
      if (start && !busy) predict_pool(in_item);
    end
  end
endmodule

@@ sim/tb.sv @@
// Testbench top for the aging slot pool: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import asp_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int IN_W = $bits(in_item_t);

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        listed_seen;
  int        idle_cycles = 0;
  int        item_count = 0;

  always #5 clk = ~clk;

  aging_slot_pool_with_overwrite uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  asp_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending(pending), .listed_seen(listed_seen)
  );

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one item after a random gap and wait for its acceptance. The block
  // stays busy after accepting an item, so the first edge of
  // the wait never delays the next item.
  task automatic send_item(in_item_t it, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    repeat (gap + 1) @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    // busy only changes at rising edges, so its value at the falling edge
    // tells whether the coming edge accepts the item.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    start <= 1'b0;
    item_count++;
  endtask

  function automatic in_item_t noise_item(req_t req);
    in_item_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = req;
    return it;
  endfunction

  // Positions near the origin so queries hit, with an occasional far one.
  function automatic logic signed [23:0] near_pos();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = noise_item(REQ_SPAWN);
    if (pick < 45) begin
      it.req_type = REQ_SPAWN;
      it.pos_x = near_pos(); it.pos_y = near_pos(); it.pos_z = near_pos();
      it.keep_forever = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: it.life_ms = 0;
        1: it.life_ms = 20'($urandom);
        default: it.life_ms = 20'($urandom_range(1, 400));
      endcase
    end else if (pick < 70) begin
      it.req_type = REQ_TICK;
      if ($urandom_range(0, 3) != 0) it.delta_ms = 16'($urandom_range(0, 150));
    end else if (pick < 97) begin
      it.req_type = REQ_QUERY;
      it.pos_x = near_pos(); it.pos_y = near_pos(); it.pos_z = near_pos();
      case ($urandom_range(0, 3))
        0: it.reach = 24'($urandom_range(0, 30));
        1: it.reach = 24'($urandom);
        default: it.reach = 24'($urandom_range(500, 5000));
      endcase
      it.list_room = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
    end else begin
      it.req_type = REQ_CLEAR;
    end
    return it;
  endfunction

  function automatic in_item_t spawn_item(logic signed [23:0] p, logic keep, logic [19:0] life);
    in_item_t it;
    it = '0;
    it.req_type = REQ_SPAWN;
    it.pos_x = p; it.pos_y = -p; it.pos_z = p;
    it.keep_forever = keep;
    it.life_ms = life;
    return it;
  endfunction

  function automatic in_item_t query_item(logic [23:0] reach, logic [4:0] room);
    in_item_t it;
    it = '0;
    it.req_type = REQ_QUERY;
    it.reach = reach;
    it.list_room = room;
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [15:0] dt);
    in_item_t it;
    it = '0;
    it.req_type = REQ_TICK;
    it.delta_ms = dt;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int settle;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of position and lifetime, full pool, overwrite, ages.
    send_item(spawn_item(24'sh7FFFFF, 1'b0, 20'hFFFFF), 1'b1);
    send_item(spawn_item(-24'sd8388608, 1'b1, 20'd0), 1'b0);
    send_item(query_item(24'hFFFFFF, 5'd31), 1'b0);
    send_item(query_item(24'd0, 5'd16), 1'b0);
    for (int i = 0; i < 14; i++)
      send_item(spawn_item(24'(i * 5), i < 3, 20'd50), 1'b0);
    // Pool is full now; these overwrite from the cursor.
    send_item(spawn_item(24'sd10, 1'b0, 20'd1), 1'b0);
    send_item(spawn_item(24'sd20, 1'b0, 20'd0), 1'b0);
    send_item(query_item(24'd25, 5'd0), 1'b0);
    send_item(tick_item(16'd0), 1'b0);
    send_item(tick_item(16'hFFFF), 1'b0);
    send_item(query_item(24'd40, 5'd5), 1'b0);
    send_item(noise_item(REQ_CLEAR), 1'b0);
    // Full pool of persistent decals refuses a spawn.
    for (int i = 0; i < 16; i++) send_item(spawn_item(24'(i), 1'b1, 20'd1), 1'b1);
    send_item(spawn_item(24'sd3, 1'b0, 20'd9), 1'b0);
    send_item(tick_item(16'd100), 1'b0);
    send_item(query_item(24'd100, 5'd16), 1'b0);

    // Pause until every expected result has come.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    send_item(noise_item(REQ_CLEAR), 1'b0);

    // Random part.
    for (int n = 0; n < 214; n++) begin
      it = rand_item();
      send_item(it, ($urandom_range(0, 39) < 8) && n > 100 && n < 160);
    end

    @(posedge clk);
    settle = 0;
    while (pending != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (60) @(posedge clk);
    $display("Sent %0d items (spawn, tick, query, clear) with random gaps;", item_count);
    $display("%0d listed entries were checked.", listed_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
